// ----- hw/rtl/rfchk_pkg.sv -----
// shared types and constants for the request frame checker
// no dependencies; every other file of the block but rfchk_if refers to this package
`timescale 1ns / 1ps

package rfchk_pkg;

    localparam int POOL_DEPTH_DEF  = 64;
    localparam int MAX_PAYLOAD_DEF = 64;

    localparam logic [7:0] MAGIC_FIRST   = 8'h69;
    localparam logic [7:0] MAGIC_SECOND  = 8'h6B;
    localparam logic [7:0] XOR_KEY_RESET = 8'h97;

    // payload positions
    localparam int KEY_START_POS  = 2;
    localparam int KEY_LAST_POS   = 5;
    localparam int BODY_START_POS = 6;

    // verdict codes
    localparam logic [1:0] V_ACCEPT    = 2'd0;
    localparam logic [1:0] V_BAD_MAGIC = 2'd1;
    localparam logic [1:0] V_DUP       = 2'd2;
    localparam logic [1:0] V_SHORT     = 2'd3;

    // result kinds
    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // configuration port
    localparam int         CFG_AW      = 3;
    localparam int         CFG_DW      = 32;
    localparam logic [0:0] REG_XOR_KEY = 1'b0;

    typedef struct packed {
        logic       kind;
        logic [7:0] body_byte;
        logic [1:0] verdict;
        logic       body_end;
    } res_t;

    typedef struct packed {
        logic        start;
        logic [31:0] key;
    } pool_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } pool_rsp_t;

endpackage

// ----- hw/rtl/rfchk_if.sv -----
// valid/ready channel interfaces for payload bytes and results
// no dependencies
`timescale 1ns / 1ps

interface rfchk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface rfchk_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] body_byte;
    logic [1:0] verdict;
    logic       body_end;

    modport source (output valid, output kind, output body_byte, output verdict,
                    output body_end, input ready);
    modport sink (input valid, input kind, input body_byte, input verdict,
                  input body_end, output ready);
endinterface

// ----- hw/rtl/rfchk_cfg.sv -----
// apb-style configuration register holding the xor decode key
// depends on rfchk_pkg
`timescale 1ns / 1ps

module rfchk_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfchk_pkg::CFG_AW-1:0]  paddr,
    input  logic [rfchk_pkg::CFG_DW-1:0]  pwdata,
    output logic [rfchk_pkg::CFG_DW-1:0]  prdata,
    output logic                          pready,
    output logic [7:0]                    xor_key
);

    logic [7:0] xor_key_reg;
    logic       key_sel;

    assign key_sel = (paddr[rfchk_pkg::CFG_AW-1:2] == rfchk_pkg::REG_XOR_KEY);
    assign pready  = 1'b1;
    assign prdata  = key_sel ? {{(rfchk_pkg::CFG_DW-8){1'b0}}, xor_key_reg}
                             : '0;
    assign xor_key = xor_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_key_reg <= rfchk_pkg::XOR_KEY_RESET;
        end
        else if (psel && penable && pwrite && pready && key_sel)
        begin
            xor_key_reg <= pwdata[7:0];
        end
    end

endmodule

// ----- hw/rtl/rfchk_pool.sv -----
// fifo pool of recent request keys, scanned one entry a cycle by one comparator
// depends on rfchk_pkg
`timescale 1ns / 1ps

module rfchk_pool
#(
    parameter int POOL_DEPTH = rfchk_pkg::POOL_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rfchk_pkg::pool_req_t  req,
    output rfchk_pkg::pool_rsp_t  rsp
);

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic PS_IDLE = 1'b0;
    localparam logic PS_SCAN = 1'b1;

    logic [31:0]   mem [POOL_DEPTH];

    logic          state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0]   key_reg;
    logic [31:0]   rd_data_reg;
    logic          rd_pend_reg;

    logic          issue;
    logic          hit_now;
    logic          miss_now;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    // ring slot of the entry that lies off places after the oldest one
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(POOL_DEPTH))
            sum = sum - SW'(POOL_DEPTH);
        return sum[AW-1:0];
    endfunction

    assign issue    = (state_reg == PS_SCAN) && (idx_reg < count_reg);
    assign rd_addr  = slot(oldest_reg, idx_reg);
    assign hit_now  = (state_reg == PS_SCAN) && rd_pend_reg && (rd_data_reg == key_reg);
    assign miss_now = (state_reg == PS_SCAN) && !issue && !rd_pend_reg;
    assign wr_en    = miss_now;
    assign wr_addr  = (count_reg < CW'(POOL_DEPTH)) ? slot(oldest_reg, count_reg)
                                                    : oldest_reg;

    assign rsp.done = hit_now || miss_now;
    assign rsp.hit  = hit_now;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        oldest_next = oldest_reg;
        idx_next    = idx_reg;
        case (state_reg)
            PS_IDLE:
            begin
                if (req.start)
                begin
                    idx_next   = '0;
                    state_next = PS_SCAN;
                end
            end
            PS_SCAN:
            begin
                if (issue)
                    idx_next = idx_reg + CW'(1);
                if (hit_now)
                begin
                    state_next = PS_IDLE;
                end
                else if (miss_now)
                begin
                    state_next = PS_IDLE;
                    if (count_reg < CW'(POOL_DEPTH))
                        count_next = count_reg + CW'(1);
                    else if (oldest_reg == AW'(POOL_DEPTH - 1))
                        oldest_next = '0;
                    else
                        oldest_next = oldest_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = PS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= PS_IDLE;
            count_reg   <= '0;
            oldest_reg  <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            oldest_reg  <= oldest_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= issue && !hit_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == PS_IDLE && req.start)
            key_reg <= req.key;
        if (issue)
            rd_data_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= key_reg;
    end

endmodule

// ----- hw/rtl/rfchk_outq.sv -----
// two-entry result queue that drives the result channel
// depends on rfchk_pkg and rfchk_if
`timescale 1ns / 1ps

module rfchk_outq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rfchk_pkg::res_t       push_data,
    output logic                  room,
    rfchk_out_if.source           result
);

    rfchk_pkg::res_t ent_reg [2];
    logic            rd_ptr_reg;
    logic            wr_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            pop;
    logic            do_push;

    assign room    = !cnt_reg[1];
    assign do_push = push && room;
    assign pop     = result.valid && result.ready;

    assign result.valid     = (cnt_reg != 2'd0);
    assign result.kind      = ent_reg[rd_ptr_reg].kind;
    assign result.body_byte = ent_reg[rd_ptr_reg].body_byte;
    assign result.verdict   = ent_reg[rd_ptr_reg].verdict;
    assign result.body_end  = ent_reg[rd_ptr_reg].body_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            case ({do_push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hw/rtl/request_frame_checker_with_replay_pool.sv -----
// top level of the request frame checker: frame sequencer, config register, key pool, result queue
// depends on rfchk_pkg, rfchk_if, rfchk_cfg, rfchk_pool, rfchk_outq
`timescale 1ns / 1ps
//
//  channel  direction  transaction
//  rx       in         one raw payload byte with frame_end
//  result   out        one decoded body byte or one frame verdict
//  apb      in         write or read of xor_key
//
//  magic, key and dropped bytes are taken in S_IDLE, followed by S_VERD when the byte also ends the frame
//  body bytes pass through S_BODY, followed by S_VERD when the byte also ends the frame
//  the fourth key byte scans the pool one entry a cycle through a single
//  32-bit comparator, staying in S_SCAN until the first hit or the last stored entry
//  reset empties the pool through its fill count, so there is no clearing pass
//  a stalled result channel holds the sequencer once the two-entry queue is full

module request_frame_checker_with_replay_pool
#(
    parameter int POOL_DEPTH  = rfchk_pkg::POOL_DEPTH_DEF,
    parameter int MAX_PAYLOAD = rfchk_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    rfchk_in_if.sink                      rx,
    rfchk_out_if.source                   result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfchk_pkg::CFG_AW-1:0]  paddr,
    input  logic [rfchk_pkg::CFG_DW-1:0]  pwdata,
    output logic [rfchk_pkg::CFG_DW-1:0]  prdata,
    output logic                          pready
);

    localparam int PW = $clog2(MAX_PAYLOAD + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_BODY = 2'd2;
    localparam logic [1:0] S_VERD = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [1:0]     rej_reg, rej_next;
    logic [31:0]    key_reg, key_next;
    logic           last_reg, last_next;
    logic           short_reg, short_next;
    logic [7:0]     body_reg, body_next;

    logic [7:0]     xor_key;
    logic [7:0]     dec;
    logic           take;
    logic [1:0]     lane;
    logic [PW-1:0]  pos_inc;
    logic [7:0]     want;
    logic           body_hit;
    logic [1:0]     verdict_now;

    rfchk_pkg::pool_req_t pool_req;
    rfchk_pkg::pool_rsp_t pool_rsp;
    rfchk_pkg::res_t      push_data;
    logic                 push;
    logic                 room;

    rfchk_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .xor_key (xor_key)
    );

    rfchk_pool #(.POOL_DEPTH(POOL_DEPTH)) u_pool
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pool_req),
        .rsp   (pool_rsp)
    );

    rfchk_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .room      (room),
        .result    (result)
    );

    assign rx.ready = (state_reg == S_IDLE);
    assign take     = rx.valid && rx.ready;
    assign dec      = rx.data_byte ^ xor_key;
    assign lane     = 2'(pos_reg - PW'(rfchk_pkg::KEY_START_POS));
    assign want     = (pos_reg == '0) ? rfchk_pkg::MAGIC_FIRST : rfchk_pkg::MAGIC_SECOND;
    assign pos_inc  = (pos_reg < PW'(MAX_PAYLOAD)) ? pos_reg + PW'(1) : pos_reg;
    assign body_hit = (pos_reg >= PW'(rfchk_pkg::BODY_START_POS))
                      && (pos_reg < PW'(MAX_PAYLOAD)) && (rej_reg == rfchk_pkg::V_ACCEPT);

    assign verdict_now = (rej_reg != rfchk_pkg::V_ACCEPT) ? rej_reg
                       : short_reg ? rfchk_pkg::V_SHORT : rfchk_pkg::V_ACCEPT;

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        rej_next      = rej_reg;
        key_next      = key_reg;
        last_next     = last_reg;
        short_next    = short_reg;
        body_next     = body_reg;
        pool_req.start = 1'b0;
        pool_req.key   = key_reg;
        push          = 1'b0;
        push_data     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    last_next  = rx.frame_end;
                    short_next = (pos_inc < PW'(rfchk_pkg::BODY_START_POS));
                    body_next  = dec;
                    pos_next   = rx.frame_end ? '0 : pos_inc;
                    state_next = rx.frame_end ? S_VERD : S_IDLE;
                    if (pos_reg < PW'(rfchk_pkg::KEY_START_POS))
                    begin
                        if (rej_reg == rfchk_pkg::V_ACCEPT && rx.data_byte != want)
                            rej_next = rfchk_pkg::V_BAD_MAGIC;
                    end
                    else if (pos_reg < PW'(rfchk_pkg::BODY_START_POS))
                    begin
                        key_next = key_reg | (32'(dec) << {lane, 3'b000});
                        if (pos_reg == PW'(rfchk_pkg::KEY_LAST_POS)
                            && rej_reg == rfchk_pkg::V_ACCEPT)
                        begin
                            pool_req.start = 1'b1;
                            pool_req.key   = key_next;
                            state_next     = S_SCAN;
                        end
                    end
                    else if (body_hit)
                    begin
                        state_next = S_BODY;
                    end
                    if (rx.frame_end)
                        key_next = '0;
                end
            end
            S_SCAN:
            begin
                if (pool_rsp.done)
                begin
                    if (pool_rsp.hit)
                        rej_next = rfchk_pkg::V_DUP;
                    state_next = last_reg ? S_VERD : S_IDLE;
                end
            end
            S_BODY:
            begin
                push_data.kind      = rfchk_pkg::KIND_BODY;
                push_data.body_byte = body_reg;
                push_data.verdict   = rfchk_pkg::V_ACCEPT;
                push_data.body_end  = 1'b0;
                push = 1'b1;
                if (room)
                    state_next = last_reg ? S_VERD : S_IDLE;
            end
            S_VERD:
            begin
                push_data.kind      = rfchk_pkg::KIND_VERDICT;
                push_data.body_byte = 8'd0;
                push_data.verdict   = verdict_now;
                push_data.body_end  = 1'b1;
                push = 1'b1;
                if (room)
                begin
                    rej_next   = rfchk_pkg::V_ACCEPT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            rej_reg   <= rfchk_pkg::V_ACCEPT;
            key_reg   <= '0;
            last_reg  <= 1'b0;
            short_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            rej_reg   <= rej_next;
            key_reg   <= key_next;
            last_reg  <= last_next;
            short_reg <= short_next;
        end
    end

    always_ff @(posedge clk)
    begin
        body_reg <= body_next;
    end

endmodule
